[design/ecfe_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Effect command frame engine package
// Operation codes, command bytes, register indexes, the slot record type and
// the helpers shared by the frame engine.
// ----------------------------------------------------------------------------
package ecfe_pkg;

  typedef enum logic [1:0] {
    OP_BYTE = 2'd0,
    OP_TICK = 2'd1,
    OP_READ = 2'd2,
    OP_NONE = 2'd3
  } ecfe_op_e;

  typedef enum logic [1:0] {
    CFG_FW_MAJOR = 2'd0,
    CFG_FW_MINOR = 2'd1,
    CFG_FW_PATCH = 2'd2,
    CFG_TIMEOUT  = 2'd3
  } ecfe_cfg_e;

  typedef enum logic [1:0] {
    JOB_BYTES = 2'd0,
    JOB_QUERY = 2'd1,
    JOB_READ  = 2'd2
  } ecfe_job_e;

  localparam logic [7:0]  CMD_SET_EFFECT    = 8'h01;
  localparam logic [7:0]  CMD_QUERY_EFFECT  = 8'h02;
  localparam logic [7:0]  CMD_QUERY_VERSION = 8'h03;
  localparam logic [7:0]  CMD_SET_TEMPO     = 8'h04;
  localparam logic [7:0]  CMD_QUERY_TEMPO   = 8'h05;

  localparam logic [15:0] TEMPO_RESET   = 16'd12000;
  localparam logic [15:0] TIMEOUT_RESET = 16'd50000;
  localparam logic [15:0] IDLE_MAX      = 16'hFFFF;

  localparam logic [7:0]  PRESET_A_SLOT = 8'd3;
  localparam logic [7:0]  PRESET_B_SLOT = 8'd4;

  typedef struct packed {
    logic       on;
    logic [7:0] pa;
    logic [7:0] pb;
    logic [7:0] pc;
    logic [7:0] mix;
  } ecfe_slot_t;

  function automatic logic [2:0] len_of_cmd(input logic [7:0] cmd);
    logic [2:0] len;
    case (cmd)
      CMD_SET_EFFECT:    len = 3'd7;
      CMD_QUERY_EFFECT:  len = 3'd2;
      CMD_QUERY_VERSION: len = 3'd1;
      CMD_SET_TEMPO:     len = 3'd3;
      CMD_QUERY_TEMPO:   len = 3'd1;
      default:           len = 3'd0;
    endcase
    return len;
  endfunction

  function automatic ecfe_slot_t slot_reset(input logic [7:0] slot);
    ecfe_slot_t s;
    s = '0;
    if (slot == PRESET_A_SLOT) begin
      s.pa = 8'h06;
      s.pb = 8'hC0;
    end else if (slot == PRESET_B_SLOT) begin
      s.pa = 8'h7F;
      s.pb = 8'h40;
    end
    return s;
  endfunction

endpackage

[design/effect_command_frame_engine.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Effect command frame engine
// Assembles command frames from received bytes, updates the effect slot
// store and the tempo register, and emits echo and response bytes.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake                Payload
//  in       input      in_valid_i / in_stall_o  operation, rx_byte, read_slot
//  out      output     out_valid_o / out_stall_i tx_byte .. tempo_now
//  cfg      input      cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
//  Input items without results can follow every cycle while in_stall_o is low.
//  A slot read or query-effect reads the slot memory through a registered port.
//  Results leave one beat per cycle while out_stall_i is low; a seven-byte response
//  holds the emitter, and one further job may wait behind it before in_stall_o rises.
//  Reset clears per-slot valid bits, so untouched slots read their preset values.
// ----------------------------------------------------------------------------
module effect_command_frame_engine
  import ecfe_pkg::*;
#(
  parameter int NUM_SLOTS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  operation_i,
  input  logic [7:0]  rx_byte_i,
  input  logic [7:0]  read_slot_i,

  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  tx_byte_o,
  output logic        tx_last_o,
  output logic        read_ok_o,
  output logic        slot_enabled_o,
  output logic [7:0]  slot_param_a_o,
  output logic [7:0]  slot_param_b_o,
  output logic [7:0]  slot_param_c_o,
  output logic [7:0]  slot_mix_o,
  output logic [15:0] tempo_now_o,

  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  localparam int SlotW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  logic [7:0]  fw_major_q, fw_minor_q, fw_patch_q;
  logic [15:0] timeout_q;

  logic [15:0] tempo_q, tempo_d;
  logic [2:0]  exp_q, exp_d;
  logic [2:0]  seen_q, seen_d;
  logic [15:0] idle_q, idle_d;
  logic [7:0]  frame_q [8];
  logic [7:0]  fb_new [8];
  logic        fb_we;
  logic [2:0]  fb_widx;

  ecfe_slot_t             slot_mem_q [NUM_SLOTS];
  logic [NUM_SLOTS-1:0]   slot_vld_q;
  logic                   mem_we;
  logic [SlotW-1:0]       mem_waddr;
  ecfe_slot_t             mem_wdata;
  logic                   rd_en;
  logic [SlotW-1:0]       rd_addr;
  ecfe_slot_t             rd_q;
  logic                   rd_vld_q;
  ecfe_slot_t             rd_slot;

  logic        job_new;
  ecfe_job_e   job_kind;
  logic [7:0]  job_bytes [7];
  logic [2:0]  job_cnt;
  logic        job_ok;

  logic        b_valid_q, b_valid_d;
  ecfe_job_e   b_kind_q;
  logic [7:0]  b_bytes_q [7];
  logic [2:0]  b_cnt_q;
  logic        b_ok_q;
  logic [SlotW-1:0] b_addr_q;
  logic [15:0] b_tempo_q;

  logic        em_valid_q, em_valid_d;
  logic [2:0]  em_idx_q, em_idx_d;
  logic [2:0]  em_cnt_q;
  logic [7:0]  em_bytes_q [7];
  logic        em_read_q;
  logic        em_ok_q;
  ecfe_slot_t  em_slot_q;
  logic [15:0] em_tempo_q;

  logic [7:0]  ld_bytes [7];
  logic        ld_read;

  logic        in_accept, taken, em_last, em_free, b_adv;
  logic [7:0]  cmd, slot;
  logic        slot_ok, rs_ok, complete;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_major_q <= '0;
      fw_minor_q <= '0;
      fw_patch_q <= '0;
      timeout_q  <= TIMEOUT_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_FW_MAJOR: fw_major_q <= cfg_data_i[7:0];
        CFG_FW_MINOR: fw_minor_q <= cfg_data_i[7:0];
        CFG_FW_PATCH: fw_patch_q <= cfg_data_i[7:0];
        CFG_TIMEOUT:  timeout_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign taken    = em_valid_q && !out_stall_i;
  assign em_last  = (em_idx_q == 3'(em_cnt_q - 3'd1));
  assign em_free  = !em_valid_q || (taken && em_last);
  assign b_adv    = b_valid_q && em_free;
  assign in_stall_o = b_valid_q && !em_free;
  assign in_accept  = in_valid_i && !in_stall_o;

  assign rs_ok = {1'b0, read_slot_i} < 9'(NUM_SLOTS);

  always_comb begin
    tempo_d   = tempo_q;
    exp_d     = exp_q;
    seen_d    = seen_q;
    idle_d    = idle_q;
    fb_we     = 1'b0;
    fb_widx   = seen_q;
    fb_new    = frame_q;
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = '0;
    rd_en     = 1'b0;
    rd_addr   = '0;
    job_new   = 1'b0;
    job_kind  = JOB_BYTES;
    job_cnt   = 3'd1;
    job_ok    = 1'b0;
    complete  = 1'b0;
    for (int i = 0; i < 7; i++) begin
      job_bytes[i] = '0;
    end
    cmd     = '0;
    slot    = '0;
    slot_ok = 1'b0;

    if (in_accept) begin
      case (operation_i)
        OP_BYTE: begin
          idle_d = '0;
          if (exp_q == 3'd0) begin
            exp_d = len_of_cmd(rx_byte_i);
            if (exp_d != 3'd0) begin
              fb_we   = 1'b1;
              fb_widx = 3'd0;
              seen_d  = 3'd1;
            end
          end else begin
            fb_we  = 1'b1;
            seen_d = 3'(seen_q + 3'd1);
          end
          if (fb_we) begin
            fb_new[fb_widx] = rx_byte_i;
            complete = (seen_d >= exp_d);
          end
          if (complete) begin
            exp_d   = 3'd0;
            seen_d  = 3'd0;
            cmd     = fb_new[0];
            slot    = fb_new[1];
            slot_ok = {1'b0, slot} < 9'(NUM_SLOTS);
            case (cmd)
              CMD_SET_EFFECT: begin
                if (slot_ok && fb_new[2][7:1] == 7'd0) begin
                  mem_we    = 1'b1;
                  mem_waddr = slot[SlotW-1:0];
                  mem_wdata = '{on: fb_new[2][0], pa: fb_new[3], pb: fb_new[4],
                                pc: fb_new[5], mix: fb_new[6]};
                  job_new   = 1'b1;
                  job_cnt   = 3'd7;
                  for (int i = 0; i < 7; i++) begin
                    job_bytes[i] = fb_new[i];
                  end
                end
              end
              CMD_QUERY_EFFECT: begin
                if (slot_ok) begin
                  rd_en        = 1'b1;
                  rd_addr      = slot[SlotW-1:0];
                  job_new      = 1'b1;
                  job_kind     = JOB_QUERY;
                  job_cnt      = 3'd7;
                  job_bytes[0] = CMD_SET_EFFECT;
                  job_bytes[1] = slot;
                end
              end
              CMD_QUERY_VERSION: begin
                job_new      = 1'b1;
                job_cnt      = 3'd4;
                job_bytes[0] = CMD_QUERY_VERSION;
                job_bytes[1] = fw_major_q;
                job_bytes[2] = fw_minor_q;
                job_bytes[3] = fw_patch_q;
              end
              CMD_SET_TEMPO: begin
                tempo_d      = {fb_new[1], fb_new[2]};
                job_new      = 1'b1;
                job_cnt      = 3'd3;
                job_bytes[0] = fb_new[0];
                job_bytes[1] = fb_new[1];
                job_bytes[2] = fb_new[2];
              end
              CMD_QUERY_TEMPO: begin
                job_new      = 1'b1;
                job_cnt      = 3'd3;
                job_bytes[0] = CMD_QUERY_TEMPO;
                job_bytes[1] = tempo_q[15:8];
                job_bytes[2] = tempo_q[7:0];
              end
              default: ;
            endcase
          end
        end
        OP_TICK: begin
          if (idle_q != IDLE_MAX) begin
            idle_d = 16'(idle_q + 16'd1);
          end
          if (exp_q != 3'd0 && idle_d > timeout_q) begin
            exp_d  = 3'd0;
            seen_d = 3'd0;
          end
        end
        OP_READ: begin
          job_new  = 1'b1;
          job_kind = JOB_READ;
          job_ok   = rs_ok;
          if (rs_ok) begin
            rd_en   = 1'b1;
            rd_addr = read_slot_i[SlotW-1:0];
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tempo_q <= TEMPO_RESET;
      exp_q   <= '0;
      seen_q  <= '0;
      idle_q  <= '0;
    end else begin
      tempo_q <= tempo_d;
      exp_q   <= exp_d;
      seen_q  <= seen_d;
      idle_q  <= idle_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fb_we) begin
      frame_q[fb_widx] <= rx_byte_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      slot_mem_q[mem_waddr] <= mem_wdata;
    end
    if (rd_en) begin
      rd_q <= slot_mem_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_vld_q <= '0;
      rd_vld_q   <= 1'b0;
    end else begin
      if (mem_we) begin
        slot_vld_q[mem_waddr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_q <= slot_vld_q[rd_addr];
      end
    end
  end

  assign rd_slot = rd_vld_q ? rd_q : slot_reset(8'(b_addr_q));

  always_comb begin
    b_valid_d = b_valid_q;
    if (in_accept && job_new) begin
      b_valid_d = 1'b1;
    end else if (b_adv) begin
      b_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else begin
      b_valid_q <= b_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept && job_new) begin
      b_kind_q  <= job_kind;
      b_bytes_q <= job_bytes;
      b_cnt_q   <= job_cnt;
      b_ok_q    <= job_ok;
      b_addr_q  <= rd_addr;
      b_tempo_q <= tempo_d;
    end
  end

  always_comb begin
    em_valid_d = em_valid_q;
    em_idx_d   = em_idx_q;
    if (b_adv) begin
      em_valid_d = 1'b1;
      em_idx_d   = 3'd0;
    end else if (taken) begin
      if (em_last) begin
        em_valid_d = 1'b0;
      end else begin
        em_idx_d = 3'(em_idx_q + 3'd1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      em_valid_q <= 1'b0;
      em_idx_q   <= '0;
    end else begin
      em_valid_q <= em_valid_d;
      em_idx_q   <= em_idx_d;
    end
  end

  always_comb begin
    ld_bytes = b_bytes_q;
    ld_read  = 1'b0;
    case (b_kind_q)
      JOB_QUERY: begin
        ld_bytes[2] = {7'd0, rd_slot.on};
        ld_bytes[3] = rd_slot.pa;
        ld_bytes[4] = rd_slot.pb;
        ld_bytes[5] = rd_slot.pc;
        ld_bytes[6] = rd_slot.mix;
      end
      JOB_READ: ld_read = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (b_adv) begin
      em_cnt_q   <= b_cnt_q;
      em_tempo_q <= b_tempo_q;
      em_ok_q    <= b_ok_q;
      em_slot_q  <= rd_slot;
      em_bytes_q <= ld_bytes;
      em_read_q  <= ld_read;
    end
  end

  assign out_valid_o    = em_valid_q;
  assign tx_byte_o      = em_read_q ? 8'd0 : em_bytes_q[em_idx_q];
  assign tx_last_o      = !em_read_q && em_last;
  assign read_ok_o      = em_read_q && em_ok_q;
  assign slot_enabled_o = read_ok_o && em_slot_q.on;
  assign slot_param_a_o = read_ok_o ? em_slot_q.pa  : 8'd0;
  assign slot_param_b_o = read_ok_o ? em_slot_q.pb  : 8'd0;
  assign slot_param_c_o = read_ok_o ? em_slot_q.pc  : 8'd0;
  assign slot_mix_o     = read_ok_o ? em_slot_q.mix : 8'd0;
  assign tempo_now_o    = em_tempo_q;

`ifndef SYNTHESIS
  a_idx_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    em_valid_q |-> (em_idx_q < em_cnt_q))
    else $error("emitter index beyond response length");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (b_valid_q && em_valid_q))
    else $error("input stalled without a waiting job");

  a_idx_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (taken && !em_last) |=> (em_valid_q && em_idx_q == 3'($past(em_idx_q) + 3'd1)))
    else $error("emitter did not advance after a taken beat");

  a_read_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (em_valid_q && em_read_q) |-> (em_cnt_q == 3'd1))
    else $error("slot read result spans more than one beat");
`endif

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Effect command frame engine testbench
// A queue-fed driver sends received bytes, timer ticks and slot reads with
// random gaps. A clocked monitor runs a cycle-free model of the frame engine
// on every accepted input beat and compares each output beat, field by
// field, with the oldest predicted reply. Configuration is rewritten between
// phases while the engine is idle, and the receiver applies random and long
// back-pressure.
// ----------------------------------------------------------------------------
module tb;
  import ecfe_pkg::*;

  localparam int SLOTS        = 8;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 20;
  localparam logic [7:0] RESP_EFFECT = 8'h01;

  typedef struct packed {
    ecfe_op_e   op;
    logic [7:0] rx;
    logic [7:0] rs;
  } item_t;

  typedef struct packed {
    logic [7:0]  tx;
    logic        last;
    logic        ok;
    logic        en;
    logic [7:0]  pa;
    logic [7:0]  pb;
    logic [7:0]  pc;
    logic [7:0]  mix;
    logic [15:0] tempo;
  } result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  operation_i = OP_NONE;
  logic [7:0]  rx_byte_i = '0;
  logic [7:0]  read_slot_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [7:0]  tx_byte_o;
  logic        tx_last_o;
  logic        read_ok_o;
  logic        slot_enabled_o;
  logic [7:0]  slot_param_a_o;
  logic [7:0]  slot_param_b_o;
  logic [7:0]  slot_param_c_o;
  logic [7:0]  slot_mix_o;
  logic [15:0] tempo_now_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = CFG_FW_MAJOR;
  logic [15:0] cfg_data_i = '0;

  item_t   pending_q[$];
  result_t reply_q[$];
  item_t   drive_item;
  item_t   seen_item;
  result_t head_reply;
  int      send_gap;
  int      stall_left;
  int      hold_left;
  bit      hold_req = 1'b0;
  bit      quiet = 1'b0;
  int      items_queued = 0;
  int      items_taken = 0;
  int      err_cnt = 0;
  logic [15:0] cur_timeout = TIMEOUT_RESET;

  ecfe_slot_t  slot_m [SLOTS];
  logic [15:0] tempo_m;
  logic [7:0]  frame_m [8];
  int          want_len_m;
  int          got_len_m;
  logic [15:0] idle_m;
  logic [7:0]  fw_major_m;
  logic [7:0]  fw_minor_m;
  logic [7:0]  fw_patch_m;
  logic [15:0] timeout_m;

  effect_command_frame_engine #(
    .NUM_SLOTS(SLOTS)
  ) DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .operation_i    (operation_i),
    .rx_byte_i      (rx_byte_i),
    .read_slot_i    (read_slot_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .tx_byte_o      (tx_byte_o),
    .tx_last_o      (tx_last_o),
    .read_ok_o      (read_ok_o),
    .slot_enabled_o (slot_enabled_o),
    .slot_param_a_o (slot_param_a_o),
    .slot_param_b_o (slot_param_b_o),
    .slot_param_c_o (slot_param_c_o),
    .slot_mix_o     (slot_mix_o),
    .tempo_now_o    (tempo_now_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 24);
  endfunction

  function automatic logic [7:0] pick_slot();
    if ($urandom_range(0, 9) < 8) return 8'($urandom_range(0, SLOTS - 1));
    return 8'($urandom_range(SLOTS, 255));
  endfunction

  function automatic logic [2:0] cmd_length(input logic [7:0] cmd);
    case (cmd)
      CMD_SET_EFFECT:    return 3'd7;
      CMD_QUERY_EFFECT:  return 3'd2;
      CMD_QUERY_VERSION: return 3'd1;
      CMD_SET_TEMPO:     return 3'd3;
      CMD_QUERY_TEMPO:   return 3'd1;
      default:           return 3'd0;
    endcase
  endfunction

  function automatic void push_reply(input logic [7:0] b, input logic last);
    result_t r;
    r = '0;
    r.tx = b;
    r.last = last;
    r.tempo = tempo_m;
    reply_q.push_back(r);
  endfunction

  task automatic engine_step(input item_t it);
    result_t    r;
    logic [7:0] s;
    case (it.op)
      OP_BYTE: begin
        idle_m = '0;
        if (want_len_m == 0) begin
          want_len_m = int'(cmd_length(it.rx));
          if (want_len_m != 0) begin
            frame_m[0] = it.rx;
            got_len_m = 1;
          end
        end else begin
          frame_m[got_len_m] = it.rx;
          got_len_m++;
        end
        if (want_len_m != 0 && got_len_m >= want_len_m) begin
          s = frame_m[1];
          case (frame_m[0])
            CMD_SET_EFFECT: begin
              if (s < SLOTS && frame_m[2] <= 8'd1) begin
                slot_m[s].on  = frame_m[2][0];
                slot_m[s].pa  = frame_m[3];
                slot_m[s].pb  = frame_m[4];
                slot_m[s].pc  = frame_m[5];
                slot_m[s].mix = frame_m[6];
                for (int k = 0; k < 7; k++) push_reply(frame_m[k], k == 6);
              end
            end
            CMD_QUERY_EFFECT: begin
              if (s < SLOTS) begin
                push_reply(RESP_EFFECT, 1'b0);
                push_reply(s, 1'b0);
                push_reply({7'd0, slot_m[s].on}, 1'b0);
                push_reply(slot_m[s].pa, 1'b0);
                push_reply(slot_m[s].pb, 1'b0);
                push_reply(slot_m[s].pc, 1'b0);
                push_reply(slot_m[s].mix, 1'b1);
              end
            end
            CMD_QUERY_VERSION: begin
              push_reply(CMD_QUERY_VERSION, 1'b0);
              push_reply(fw_major_m, 1'b0);
              push_reply(fw_minor_m, 1'b0);
              push_reply(fw_patch_m, 1'b1);
            end
            CMD_SET_TEMPO: begin
              tempo_m = {frame_m[1], frame_m[2]};
              for (int k = 0; k < 3; k++) push_reply(frame_m[k], k == 2);
            end
            CMD_QUERY_TEMPO: begin
              push_reply(CMD_QUERY_TEMPO, 1'b0);
              push_reply(tempo_m[15:8], 1'b0);
              push_reply(tempo_m[7:0], 1'b1);
            end
            default: ;
          endcase
          want_len_m = 0;
          got_len_m = 0;
        end
      end
      OP_TICK: begin
        if (idle_m != IDLE_MAX) idle_m++;
        if (want_len_m != 0 && idle_m > timeout_m) begin
          want_len_m = 0;
          got_len_m = 0;
        end
      end
      OP_READ: begin
        r = '0;
        r.tempo = tempo_m;
        if (it.rs < SLOTS) begin
          r.ok  = 1'b1;
          r.en  = slot_m[it.rs].on;
          r.pa  = slot_m[it.rs].pa;
          r.pb  = slot_m[it.rs].pb;
          r.pc  = slot_m[it.rs].pc;
          r.mix = slot_m[it.rs].mix;
        end
        reply_q.push_back(r);
      end
      default: ;
    endcase
  endtask

  task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0h, actual %0h", $time, name, want, got);
      err_cnt++;
    end
  endtask

  // Driver: one beat per handshake, random gap after each beat.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      operation_i <= OP_NONE;
      rx_byte_i <= '0;
      read_slot_i <= '0;
      send_gap = 0;
    end else if (!in_valid_i || !in_stall_o) begin
      if (send_gap > 0) begin
        in_valid_i <= 1'b0;
        send_gap--;
      end else if (pending_q.size() != 0) begin
        drive_item = pending_q.pop_front();
        in_valid_i <= 1'b1;
        operation_i <= drive_item.op;
        rx_byte_i <= drive_item.rx;
        read_slot_i <= drive_item.rs;
        send_gap = quiet ? 0 : pick_gap();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver back-pressure, with an occasional long hold-off.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left = 0;
      hold_left = 0;
    end else begin
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else if (stall_left > 0) begin
        out_stall_i <= 1'b1;
        stall_left--;
      end else begin
        out_stall_i <= 1'b0;
        stall_left = quiet ? 0 : pick_gap();
      end
    end
  end

  // Monitor: predict on each input beat, then check each output beat.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SLOTS; i++) slot_m[i] = '0;
      slot_m[PRESET_A_SLOT].pa = 8'h06;
      slot_m[PRESET_A_SLOT].pb = 8'hC0;
      slot_m[PRESET_B_SLOT].pa = 8'h7F;
      slot_m[PRESET_B_SLOT].pb = 8'h40;
      tempo_m = TEMPO_RESET;
      want_len_m = 0;
      got_len_m = 0;
      idle_m = '0;
      fw_major_m = '0;
      fw_minor_m = '0;
      fw_patch_m = '0;
      timeout_m = TIMEOUT_RESET;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CFG_FW_MAJOR: fw_major_m = cfg_data_i[7:0];
          CFG_FW_MINOR: fw_minor_m = cfg_data_i[7:0];
          CFG_FW_PATCH: fw_patch_m = cfg_data_i[7:0];
          CFG_TIMEOUT:  timeout_m  = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_o) begin
        seen_item.op = ecfe_op_e'(operation_i);
        seen_item.rx = rx_byte_i;
        seen_item.rs = read_slot_i;
        engine_step(seen_item);
        items_taken++;
      end
      if (out_valid_o && !out_stall_i) begin
        if (reply_q.size() == 0) begin
          $display("%0t: output beat with nothing expected, actual tx_byte %0h", $time,
                   tx_byte_o);
          err_cnt++;
        end else begin
          head_reply = reply_q.pop_front();
          check_field("tx_byte", 16'(head_reply.tx), 16'(tx_byte_o));
          check_field("tx_last", 16'(head_reply.last), 16'(tx_last_o));
          check_field("read_ok", 16'(head_reply.ok), 16'(read_ok_o));
          check_field("slot_enabled", 16'(head_reply.en), 16'(slot_enabled_o));
          check_field("slot_param_a", 16'(head_reply.pa), 16'(slot_param_a_o));
          check_field("slot_param_b", 16'(head_reply.pb), 16'(slot_param_b_o));
          check_field("slot_param_c", 16'(head_reply.pc), 16'(slot_param_c_o));
          check_field("slot_mix", 16'(head_reply.mix), 16'(slot_mix_o));
          check_field("tempo_now", head_reply.tempo, tempo_now_o);
        end
      end
    end
  end

  task automatic queue_beat(input ecfe_op_e op, input logic [7:0] rx, input logic [7:0] rs);
    item_t it;
    it.op = op;
    it.rx = rx;
    it.rs = rs;
    pending_q.push_back(it);
    items_queued++;
  endtask

  task automatic send_byte(input logic [7:0] b);
    queue_beat(OP_BYTE, b, 8'($urandom_range(0, 255)));
  endtask

  task automatic send_tick();
    queue_beat(OP_TICK, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
  endtask

  task automatic send_read(input logic [7:0] slot);
    queue_beat(OP_READ, 8'($urandom_range(0, 255)), slot);
  endtask

  task automatic send_set_effect(input logic [7:0] slot, input logic [7:0] on,
                                 input logic [7:0] a, input logic [7:0] b,
                                 input logic [7:0] c, input logic [7:0] mix);
    send_byte(CMD_SET_EFFECT);
    send_byte(slot);
    send_byte(on);
    send_byte(a);
    send_byte(b);
    send_byte(c);
    send_byte(mix);
  endtask

  task automatic send_query_effect(input logic [7:0] slot);
    send_byte(CMD_QUERY_EFFECT);
    send_byte(slot);
  endtask

  task automatic send_set_tempo(input logic [15:0] t);
    send_byte(CMD_SET_TEMPO);
    send_byte(t[15:8]);
    send_byte(t[7:0]);
  endtask

  task automatic cfg_write(input ecfe_cfg_e idx, input logic [15:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == CFG_TIMEOUT) cur_timeout = val;
  endtask

  task automatic write_all(input logic [7:0] major, input logic [7:0] minor,
                           input logic [7:0] patch, input logic [15:0] timeout);
    cfg_write(CFG_FW_MAJOR, {8'd0, major});
    cfg_write(CFG_FW_MINOR, {8'd0, minor});
    cfg_write(CFG_FW_PATCH, {8'd0, patch});
    cfg_write(CFG_TIMEOUT, timeout);
  endtask

  task automatic wait_drained();
    while (items_taken != items_queued || reply_q.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic random_frame();
    int kind;
    kind = $urandom_range(0, 4);
    case (kind)
      0: send_set_effect(pick_slot(),
                         ($urandom_range(0, 7) == 0) ? 8'($urandom_range(2, 255))
                                                     : 8'($urandom_range(0, 1)),
                         8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
      1: send_query_effect(pick_slot());
      2: send_byte(CMD_QUERY_VERSION);
      3: send_set_tempo(16'($urandom));
      default: send_byte(CMD_QUERY_TEMPO);
    endcase
  endtask

  task automatic random_phase(input int n_items);
    int start;
    int kind;
    int n;
    start = items_queued;
    while (items_queued - start < n_items) begin
      kind = $urandom_range(0, 99);
      if (kind < 68) begin
        random_frame();
      end else if (kind < 76) begin
        send_tick();
      end else if (kind < 85) begin
        send_read(pick_slot());
      end else if (kind < 88) begin
        queue_beat(OP_NONE, 8'($urandom), 8'($urandom));
      end else if (kind < 93) begin
        send_byte(8'($urandom));
      end else begin
        send_byte(($urandom_range(0, 1) == 0) ? CMD_SET_EFFECT : CMD_SET_TEMPO);
        n = $urandom_range(0, 1);
        repeat (n) send_byte(8'($urandom));
        n = (cur_timeout < 8) ? int'(cur_timeout) + $urandom_range(1, 2)
                              : $urandom_range(1, 3);
        repeat (n) send_tick();
      end
    end
  endtask

  initial begin : stimulus
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    send_read(PRESET_A_SLOT);
    send_read(PRESET_B_SLOT);
    send_read(8'(SLOTS));
    send_read(8'hFF);
    send_byte(CMD_QUERY_VERSION);
    send_byte(CMD_QUERY_TEMPO);
    queue_beat(OP_NONE, 8'hFF, 8'hFF);
    send_byte(8'h00);
    send_byte(8'hFF);
    wait_drained();

    write_all(8'hFF, 8'h00, 8'hA5, 16'd1);
    send_set_effect(8'(SLOTS - 1), 8'd1, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    send_set_tempo(16'hFFFF);
    send_byte(CMD_QUERY_VERSION);
    send_byte(CMD_QUERY_EFFECT);
    send_tick();
    send_byte(8'(SLOTS - 1));
    send_byte(CMD_QUERY_EFFECT);
    send_tick();
    send_tick();
    send_byte(CMD_QUERY_TEMPO);
    wait_drained();

    cfg_write(CFG_TIMEOUT, 16'd0);
    send_byte(CMD_SET_TEMPO);
    send_tick();
    send_byte(CMD_QUERY_VERSION);
    wait_drained();

    write_all(8'($urandom), 8'($urandom), 8'($urandom), 16'($urandom_range(1, 6)));
    random_phase(14);
    hold_req = 1'b1;
    repeat (6) send_query_effect(8'($urandom_range(0, SLOTS - 1)));
    random_phase(14);
    wait_drained();

    write_all(8'h00, 8'hFF, 8'h00, 16'hFFFF);
    random_phase(18);
    wait_drained();

    quiet = 1'b1;
    write_all(8'($urandom), 8'($urandom), 8'($urandom), 16'($urandom_range(2, 10)));
    random_phase(18);
    wait_drained();

    if (err_cnt == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("tb: errors");
    $finish;
  end

endmodule
